[rtl/core/assert_macros.svh]
// Assertion macros shared by the delta varint encoder RTL.
// Standalone header; no dependencies. Compiled out when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// expr must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_HOLDS(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

[rtl/core/dvte_pkg.sv]
// Package for the delta varint table encoder: descriptor types and queue sizing.
// No dependencies.
package dvte_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   // One classified element, ready for serialization
   typedef struct packed {
      logic        first;      // emit count byte and signed form
      logic [7:0]  count_byte; // set count mod 256
      logic        neg;        // sign of first element
      logic [31:0] value;      // magnitude (first) or wrapped delta (later)
   } dvte_desc_type;

   typedef struct packed {
      logic          valid;
      dvte_desc_type desc;
   } dvte_slot_type;

endpackage

[rtl/core/dvte_front.sv]
// Front end: takes elements, forms magnitude or delta, keeps the previous element.
// Depends on dvte_pkg.
module dvte_front
   import dvte_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic                q_full,
   input  logic signed [31:0]  req_element_value,
   input  logic                req_first_element,
   input  logic [8:0]          req_set_count,
   output dvte_slot_type       enq
);

   logic [31:0] prev_ff;
   logic [31:0] prev_in;
   logic [31:0] raw;
   logic        accept;
   logic        neg;

   assign raw    = 32'(req_element_value);
   assign accept = push & ~q_full;
   assign neg    = req_first_element & raw[31];

   always_comb begin
      enq.valid           = accept;
      enq.desc.first      = req_first_element;
      enq.desc.count_byte = req_set_count[7:0];
      enq.desc.neg        = neg;
      if (req_first_element) begin
         enq.desc.value = neg ? (32'd0 - raw) : raw;
      end else begin
         enq.desc.value = raw - prev_ff;   // wraps mod 2^32
      end
      prev_in = accept ? raw : prev_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else begin
         prev_ff <= prev_in;
      end
   end

endmodule

[rtl/core/dvte_queue.sv]
// Two-entry descriptor queue between the front end and the serializer.
// Depends on dvte_pkg and assert_macros.svh.
`include "assert_macros.svh"
module dvte_queue
   import dvte_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dvte_slot_type enq,
   input  logic          deq,
   output logic          full,
   output dvte_slot_type head
);

   dvte_desc_type          mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] cnt_ff;
   logic [QUEUE_CNT_W-1:0] cnt_in;

   assign full       = (cnt_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head.valid = (cnt_ff != '0);
   assign head.desc  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = enq.valid ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = deq ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (enq.valid && !deq) begin
         cnt_in = cnt_ff + QUEUE_CNT_W'(1);
      end else if (!enq.valid && deq) begin
         cnt_in = cnt_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq.valid) begin
         mem_ff[wr_ptr_ff] <= enq.desc;
      end
   end

   `ASSERT_HOLDS(a_cnt_bound, clock, reset, cnt_ff <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue overfilled")
   `ASSERT_NEVER(a_deq_empty, clock, reset, deq && cnt_ff == '0, "dequeue from empty queue")
   `ASSERT_NEVER(a_enq_full, clock, reset, enq.valid && full, "enqueue into full queue")

endmodule

[rtl/core/dvte_back.sv]
// Back end: serializes one descriptor into count, signed and 7-bit group bytes.
// Depends on dvte_pkg and assert_macros.svh.
`include "assert_macros.svh"
module dvte_back
   import dvte_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dvte_slot_type head,
   output logic          deq,
   input  logic          pop,
   output logic          empty,
   output logic [7:0]    rsp_out_byte,
   output logic          rsp_last_of_item
);

   typedef enum logic [1:0] {ST_IDLE, ST_SIGNED, ST_GROUPS} state_type;

   state_type   state_ff, state_in;
   logic [31:0] val_ff, val_in;
   logic        neg_ff, neg_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic        ovalid_ff, ovalid_in;

   logic        adv;
   logic        cur_valid;
   logic [7:0]  cur_byte;
   logic        cur_last;
   state_type   cur_next;
   logic [31:0] cur_rest;
   logic [31:0] grp_src;
   logic [31:0] grp_rest;
   logic [31:0] sgn_rest;

   assign adv     = ~ovalid_ff | pop;
   assign grp_src = (state_ff == ST_IDLE) ? head.desc.value : val_ff;
   assign grp_rest = grp_src >> 7;
   assign sgn_rest = val_ff >> 6;

   always_comb begin
      cur_valid = 1'b1;
      cur_byte  = {(grp_rest != '0), grp_src[6:0]};
      cur_last  = (grp_rest == '0);
      cur_rest  = grp_rest;
      cur_next  = (grp_rest != '0) ? ST_GROUPS : ST_IDLE;
      case (state_ff)
         ST_IDLE: begin
            cur_valid = head.valid;
            if (head.desc.first) begin
               cur_byte = head.desc.count_byte;
               cur_last = 1'b0;
               cur_rest = head.desc.value;
               cur_next = ST_SIGNED;
            end
         end
         ST_SIGNED: begin
            cur_byte = {(sgn_rest != '0), neg_ff, val_ff[5:0]};
            cur_last = (sgn_rest == '0);
            cur_rest = sgn_rest;
            cur_next = (sgn_rest != '0) ? ST_GROUPS : ST_IDLE;
         end
         ST_GROUPS: begin
         end
         default: begin
            cur_valid = 1'b0;
         end
      endcase
   end

   always_comb begin
      deq       = (state_ff == ST_IDLE) & head.valid & adv;
      state_in  = state_ff;
      val_in    = val_ff;
      neg_in    = neg_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      ovalid_in = ovalid_ff;
      if (adv) begin
         ovalid_in = cur_valid;
         if (cur_valid) begin
            byte_in  = cur_byte;
            last_in  = cur_last;
            state_in = cur_next;
            val_in   = cur_rest;
            if (state_ff == ST_IDLE) begin
               neg_in = head.desc.neg;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
      end
      val_ff  <= val_in;
      neg_ff  <= neg_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign empty            = ~ovalid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_last_of_item = last_ff;

   `ASSERT_HOLDS(a_last_to_idle, clock, reset, (adv && cur_valid && cur_last) |=> state_ff == ST_IDLE, "no return to idle after last byte")
   `ASSERT_HOLDS(a_busy_nonzero, clock, reset, (state_ff == ST_GROUPS) |-> val_ff != '0, "group phase with nothing left")
   `ASSERT_HOLDS(a_busy_has_out, clock, reset, (state_ff != ST_IDLE) |-> ovalid_ff, "busy without a pending byte")

endmodule

[rtl/core/delta_varint_table_encoder.sv]
// Top level of the delta varint table encoder: front end, descriptor queue, serializer.
// Depends on dvte_pkg, dvte_front, dvte_queue and dvte_back.
//
//  Channel   | Handshake          | Transaction payload
//  ----------+--------------------+----------------------------------------------
//  request   | push / full        | req_element_value, req_first_element, req_set_count
//  response  | pop / empty        | rsp_out_byte, rsp_last_of_item
//
// One output byte per cycle unless pop stalls. A later element gives 1 to 5 bytes, a
// first element 2 to 6 (count byte plus signed form); the single-byte serializer in
// dvte_back sets this. The front end classifies in the accept cycle and the queue holds
// two elements, so requests flow until it fills while the serializer is busy or stalls.
// Reset (synchronous) empties the queue and output register and zeroes the
// previous element; there is no clearing pass.
module delta_varint_table_encoder
   import dvte_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request side
   input  logic               push,
   output logic               full,
   input  logic signed [31:0] req_element_value,
   input  logic               req_first_element,
   input  logic [8:0]         req_set_count,
   // response side
   output logic               empty,
   input  logic               pop,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last_of_item
);

   dvte_slot_type enq;    // classified element into the queue
   dvte_slot_type head;   // oldest queued element
   logic          deq;
   logic          q_full;

   assign full = q_full;

   // Front end: magnitude of a first element, wrapped delta of a later one
   dvte_front u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .q_full            (q_full),
      .req_element_value (req_element_value),
      .req_first_element (req_first_element),
      .req_set_count     (req_set_count),
      .enq               (enq)
   );

   // Decouples accept from serialization
   dvte_queue u_queue (
      .clock (clock),
      .reset (reset),
      .enq   (enq),
      .deq   (deq),
      .full  (q_full),
      .head  (head)
   );

   // Serializer with registered output byte
   dvte_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .deq              (deq),
      .pop              (pop),
      .empty            (empty),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_of_item (rsp_last_of_item)
   );

endmodule
